// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_SAME_CYCLE(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");

`define ASSERT_NEXT_CYCLE(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");

`else

`define ASSERT_SAME_CYCLE(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT_CYCLE(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/kwsd_pkg.sv -----
// ---------------------------------------------------------------------------
// Keyword substitution decoder package
// Widths, character codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package kwsd_pkg;

  localparam int ALPHABET_LETTERS = 26;
  localparam int CODE_W           = 5;
  localparam int CHAR_W           = 8;
  localparam int KEY_WORD_W       = 60;
  localparam int KEY_HIGH_W       = 10;
  localparam int KEY_LEN_W        = 5;
  localparam int CFG_INDEX_W      = 2;
  localparam int LETTERS_PER_WORD = 12;

  localparam logic [CHAR_W-1:0] CODE_A       = 8'd65;
  localparam logic [CHAR_W-1:0] CODE_Z       = 8'd90;
  localparam logic [CHAR_W-1:0] CODE_SPACE   = 8'd32;
  localparam logic [CHAR_W-1:0] CODE_UNKNOWN = 8'd64;

  localparam logic [CODE_W-1:0] LAST_LETTER = 5'(ALPHABET_LETTERS - 1);
  localparam logic [CODE_W-1:0] NUM_LETTERS = 5'(ALPHABET_LETTERS);

  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_MID  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LEN  = 2'd3;

  typedef struct packed {
    logic clear;
    logic key_step;
    logic fill_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic key_empty;
    logic key_last;
    logic fill_last;
  } dp_status_t;

endpackage

// ----- hw/rtl/keyword_substitution_decoder.sv -----
// ---------------------------------------------------------------------------
// Keyword substitution decoder
// Decodes keyword substitution ciphertext one byte per request.
//
//   Channel  Ports                                     Direction
//   input    in_valid, in_ready, in_cipher_char        in
//   result   out_valid, out_ready, out_plain_char      out
//   config   cfg_we, cfg_index, cfg_data               in
//
// After reset and after every register write the position table is rebuilt:
// one key step per keyword letter in use (none when the keyword is empty),
// then one fill step per letter of the alphabet.
// No request is taken during that build.
// Once built, one request is taken per cycle while no result waits or out_ready
// is high; the result is registered and holds back the next request until taken.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module keyword_substitution_decoder (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [kwsd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [kwsd_pkg::KEY_WORD_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [kwsd_pkg::CHAR_W-1:0]         in_cipher_char,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [kwsd_pkg::CHAR_W-1:0]         out_plain_char
);

  kwsd_pkg::ctrl_cmd_t  cmd;
  kwsd_pkg::dp_status_t status;

  kwsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .status    (status),
    .cmd       (cmd),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  kwsd_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .status         (status),
    .in_cipher_char (in_cipher_char),
    .out_plain_char (out_plain_char)
  );

  `ASSERT_NEXT_CYCLE(a_cfg_rebuild, clk, rst_n, cfg_we, !in_ready)
  `ASSERT_NEXT_CYCLE(a_accept_result, clk, rst_n, in_valid && in_ready, out_valid)
  `ASSERT_NEXT_CYCLE(a_space_kept, clk, rst_n, in_valid && in_ready && in_cipher_char == kwsd_pkg::CODE_SPACE, out_plain_char == kwsd_pkg::CODE_SPACE)
  `ASSERT_NEXT_CYCLE(a_high_unknown, clk, rst_n, in_valid && in_ready && in_cipher_char > kwsd_pkg::CODE_Z, out_plain_char == kwsd_pkg::CODE_UNKNOWN)

endmodule

// ----- hw/rtl/kwsd_dp.sv -----
// ---------------------------------------------------------------------------
// Keyword substitution decoder datapath
// Key registers, position table build steps and the per-character lookup.
// ---------------------------------------------------------------------------
module kwsd_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [kwsd_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [kwsd_pkg::KEY_WORD_W-1:0]        cfg_data,
  input  kwsd_pkg::ctrl_cmd_t                    cmd,
  output kwsd_pkg::dp_status_t                   status,
  input  logic [kwsd_pkg::CHAR_W-1:0]            in_cipher_char,
  output logic [kwsd_pkg::CHAR_W-1:0]            out_plain_char
);

  logic [kwsd_pkg::KEY_WORD_W-1:0] key_low_r;
  logic [kwsd_pkg::KEY_WORD_W-1:0] key_mid_r;
  logic [kwsd_pkg::KEY_HIGH_W-1:0] key_high_r;
  logic [kwsd_pkg::KEY_LEN_W-1:0]  key_len_r;

  logic [kwsd_pkg::CODE_W-1:0] table_r [kwsd_pkg::ALPHABET_LETTERS];
  logic [kwsd_pkg::ALPHABET_LETTERS-1:0] seen_r;
  logic [kwsd_pkg::CODE_W-1:0] step_r;
  logic [kwsd_pkg::CODE_W-1:0] pos_r;
  logic [kwsd_pkg::CHAR_W-1:0] out_char_r;
  logic [kwsd_pkg::CHAR_W-1:0] out_char_nxt;

  logic [kwsd_pkg::CODE_W-1:0] key_codes [kwsd_pkg::ALPHABET_LETTERS];
  logic [kwsd_pkg::CODE_W-1:0] key_len_c;
  logic [kwsd_pkg::CODE_W-1:0] cur_code;
  logic                        key_hit;
  logic                        fill_hit;
  logic [kwsd_pkg::CHAR_W-1:0] char_off;

  always_comb begin
    for (int i = 0; i < kwsd_pkg::LETTERS_PER_WORD; i++) begin
      key_codes[i] = key_low_r[i*kwsd_pkg::CODE_W +: kwsd_pkg::CODE_W];
      key_codes[i+kwsd_pkg::LETTERS_PER_WORD] =
        key_mid_r[i*kwsd_pkg::CODE_W +: kwsd_pkg::CODE_W];
    end
    for (int i = 0; i < 2; i++) begin
      key_codes[i+2*kwsd_pkg::LETTERS_PER_WORD] =
        key_high_r[i*kwsd_pkg::CODE_W +: kwsd_pkg::CODE_W];
    end
  end

  assign key_len_c = (key_len_r > kwsd_pkg::NUM_LETTERS) ? kwsd_pkg::NUM_LETTERS : key_len_r;
  assign cur_code  = (step_r <= kwsd_pkg::LAST_LETTER) ? key_codes[step_r] : '0;
  assign key_hit   = (cur_code <= kwsd_pkg::LAST_LETTER) && !seen_r[cur_code];
  assign fill_hit  = (step_r <= kwsd_pkg::LAST_LETTER) && !seen_r[step_r];

  assign status.key_empty = (key_len_c == '0);
  assign status.key_last  = (step_r == key_len_c - 5'd1);
  assign status.fill_last = (step_r == kwsd_pkg::LAST_LETTER);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_mid_r  <= '0;
      key_high_r <= '0;
      key_len_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        kwsd_pkg::REG_KEY_LOW:  key_low_r  <= cfg_data;
        kwsd_pkg::REG_KEY_MID:  key_mid_r  <= cfg_data;
        kwsd_pkg::REG_KEY_HIGH: key_high_r <= cfg_data[kwsd_pkg::KEY_HIGH_W-1:0];
        kwsd_pkg::REG_KEY_LEN:  key_len_r  <= cfg_data[kwsd_pkg::KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      step_r <= '0;
      pos_r  <= '0;
    end else if (cmd.clear) begin
      seen_r <= '0;
      step_r <= '0;
      pos_r  <= '0;
    end else if (cmd.key_step) begin
      if (key_hit) begin
        seen_r[cur_code] <= 1'b1;
        pos_r            <= pos_r + 5'd1;
      end
      step_r <= status.key_last ? '0 : step_r + 5'd1;
    end else if (cmd.fill_step) begin
      if (fill_hit) begin
        pos_r <= pos_r + 5'd1;
      end
      step_r <= step_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.key_step && key_hit) begin
      table_r[cur_code] <= pos_r;
    end else if (cmd.fill_step && fill_hit) begin
      table_r[step_r] <= pos_r;
    end
  end

  assign char_off = in_cipher_char - kwsd_pkg::CODE_A;

  always_comb begin
    if (in_cipher_char == kwsd_pkg::CODE_SPACE) begin
      out_char_nxt = kwsd_pkg::CODE_SPACE;
    end else if (in_cipher_char >= kwsd_pkg::CODE_A && in_cipher_char <= kwsd_pkg::CODE_Z) begin
      out_char_nxt = kwsd_pkg::CODE_A + {3'b000, table_r[char_off[kwsd_pkg::CODE_W-1:0]]};
    end else begin
      out_char_nxt = kwsd_pkg::CODE_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_char_r <= out_char_nxt;
    end
  end

  assign out_plain_char = out_char_r;

endmodule

// ----- hw/rtl/kwsd_ctrl.sv -----
// ---------------------------------------------------------------------------
// Keyword substitution decoder controller
// Sequences the table build and runs the request handshakes.
// ---------------------------------------------------------------------------
module kwsd_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  kwsd_pkg::dp_status_t  status,
  output kwsd_pkg::ctrl_cmd_t   cmd,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready
);

  typedef enum logic [1:0] {
    ST_KEY,
    ST_FILL,
    ST_RUN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   accept;

  assign in_ready = (state_r == ST_RUN) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    cmd.load_out = accept;
    if (cfg_we) begin
      cmd.clear = 1'b1;
      state_nxt = ST_KEY;
    end else begin
      case (state_r)
        ST_KEY: begin
          if (status.key_empty) begin
            state_nxt = ST_FILL;
          end else begin
            cmd.key_step = 1'b1;
            if (status.key_last) begin
              state_nxt = ST_FILL;
            end
          end
        end
        ST_FILL: begin
          cmd.fill_step = 1'b1;
          if (status.fill_last) begin
            state_nxt = ST_RUN;
          end
        end
        ST_RUN: begin
          state_nxt = ST_RUN;
        end
        default: begin
          state_nxt = ST_KEY;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_KEY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- tb/tb_keyword_substitution_decoder.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Keyword substitution decoder testbench
// Sends ciphertext bytes through the decoder under several keywords and
// compares every decoded byte against a behavioral prediction of the cipher
// alphabet. The keywords include repeated letters, codes above Z, oversized
// lengths and the plain alphabet. Both handshakes stall at random, and one
// long result stall backs up the block.
// ---------------------------------------------------------------------------
module tb_keyword_substitution_decoder;
  import kwsd_pkg::*;

  localparam int HOLD_CYCLES = 200;
  localparam int QUIET_LIMIT = 3000;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int RANDOM_PHASES = 8;
  localparam logic [CHAR_W-1:0] PROBE_CHARS [12] = '{
    8'h00, 8'hFF, 8'h20, 8'h41, 8'h5A, 8'h40,
    8'h5B, 8'h61, 8'h7A, 8'h80, 8'h4D, 8'h31
  };
  localparam logic [CHAR_W-1:0] KEYED_PROBES [8] = '{
    8'h4B, 8'h45, 8'h59, 8'h41, 8'h42, 8'h5A, 8'h20, 8'h71
  };

  typedef struct {
    logic [CHAR_W-1:0] cipher;
    logic [CHAR_W-1:0] plain;
  } decode_pair_t;

  class keyword_decode_tracker;
    logic [KEY_WORD_W-1:0] key_low;
    logic [KEY_WORD_W-1:0] key_mid;
    logic [KEY_HIGH_W-1:0] key_high;
    logic [KEY_LEN_W-1:0]  key_len;
    logic [CODE_W-1:0]     letter_pos [ALPHABET_LETTERS];
    bit                    positions_valid;
    decode_pair_t          plain_expected [$];
    int                    faults;

    function new();
      key_low = '0;
      key_mid = '0;
      key_high = '0;
      key_len = '0;
      positions_valid = 1'b0;
      faults = 0;
    endfunction

    function void note_write(logic [CFG_INDEX_W-1:0] idx, logic [KEY_WORD_W-1:0] data);
      case (idx)
        REG_KEY_LOW: key_low = data;
        REG_KEY_MID: key_mid = data;
        REG_KEY_HIGH: key_high = data[KEY_HIGH_W-1:0];
        REG_KEY_LEN: key_len = data[KEY_LEN_W-1:0];
        default: return;
      endcase
      positions_valid = 1'b0;
    endfunction

    function logic [CODE_W-1:0] key_code(int i);
      if (i < LETTERS_PER_WORD) return key_low[CODE_W*i +: CODE_W];
      if (i < 2 * LETTERS_PER_WORD) begin
        return key_mid[CODE_W*(i-LETTERS_PER_WORD) +: CODE_W];
      end
      return key_high[CODE_W*((i - 2*LETTERS_PER_WORD) & 1) +: CODE_W];
    endfunction

    function void rebuild_positions();
      logic [ALPHABET_LETTERS-1:0] seen;
      logic [CODE_W-1:0] c;
      int len;
      int next_pos;
      len = (key_len > ALPHABET_LETTERS) ? ALPHABET_LETTERS : int'(key_len);
      seen = '0;
      next_pos = 0;
      for (int i = 0; i < len; i++) begin
        c = key_code(i);
        if (c < ALPHABET_LETTERS && !seen[c]) begin
          letter_pos[c] = CODE_W'(next_pos);
          next_pos++;
          seen[c] = 1'b1;
        end
      end
      for (int i = 0; i < ALPHABET_LETTERS; i++) begin
        if (!seen[i]) begin
          letter_pos[i] = CODE_W'(next_pos);
          next_pos++;
          seen[i] = 1'b1;
        end
      end
      positions_valid = 1'b1;
    endfunction

    function logic [CHAR_W-1:0] decode_char(logic [CHAR_W-1:0] c);
      if (!positions_valid) rebuild_positions();
      if (c == CODE_SPACE) return CODE_SPACE;
      if (c >= CODE_A && c <= CODE_Z) return CHAR_W'(CODE_A + letter_pos[c - CODE_A]);
      return CODE_UNKNOWN;
    endfunction

    function void note_cipher(logic [CHAR_W-1:0] c);
      decode_pair_t p;
      p.cipher = c;
      p.plain = decode_char(c);
      plain_expected.push_back(p);
    endfunction

    function void check_plain(logic [CHAR_W-1:0] actual);
      decode_pair_t p;
      if (plain_expected.size() == 0) begin
        faults++;
        if (faults <= 10) $display("unexpected result 0x%02h with no request pending", actual);
        return;
      end
      p = plain_expected.pop_front();
      if (actual !== p.plain) begin
        faults++;
        if (faults <= 10) begin
          $display("mismatch: cipher 0x%02h expected plain 0x%02h got 0x%02h",
                   p.cipher, p.plain, actual);
        end
      end
    endfunction

    function int pending();
      return plain_expected.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [KEY_WORD_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [CHAR_W-1:0]      in_cipher_char = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [CHAR_W-1:0]      out_plain_char;

  keyword_decode_tracker tracker = new();
  logic [CODE_W-1:0] key_codes [ALPHABET_LETTERS];
  bit steady = 1'b0;
  bit hold_pending = 1'b0;
  int quiet_cycles = 0;

  keyword_substitution_decoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cipher_char (in_cipher_char),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_plain_char (out_plain_char)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [KEY_WORD_W-1:0] rand_word();
    return KEY_WORD_W'({$urandom(), $urandom()});
  endfunction

  function automatic logic [CHAR_W-1:0] random_cipher();
    int r;
    r = $urandom_range(99);
    if (r < 78) return CHAR_W'(CODE_A + $urandom_range(ALPHABET_LETTERS - 1));
    if (r < 86) return CODE_SPACE;
    return CHAR_W'($urandom);
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [KEY_WORD_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    tracker.note_write(idx, data);
  endtask

  task automatic program_key(input logic [KEY_WORD_W-1:0] low, mid, high, len);
    logic [KEY_WORD_W-1:0]  value [4];
    logic [CFG_INDEX_W-1:0] order [4];
    logic [CFG_INDEX_W-1:0] swap;
    int j;
    value[REG_KEY_LOW] = low;
    value[REG_KEY_MID] = mid;
    value[REG_KEY_HIGH] = high;
    value[REG_KEY_LEN] = len;
    order = '{REG_KEY_LOW, REG_KEY_MID, REG_KEY_HIGH, REG_KEY_LEN};
    for (int i = 3; i > 0; i--) begin
      j = $urandom_range(i);
      swap = order[i];
      order[i] = order[j];
      order[j] = swap;
    end
    foreach (order[k]) write_reg(order[k], value[order[k]]);
    cfg_we <= 1'b0;
  endtask

  task automatic load_keyword(input logic [KEY_LEN_W-1:0] len);
    logic [KEY_WORD_W-1:0] low;
    logic [KEY_WORD_W-1:0] mid;
    logic [KEY_WORD_W-1:0] high;
    logic [KEY_WORD_W-1:0] len_word;
    for (int i = 0; i < LETTERS_PER_WORD; i++) begin
      low[CODE_W*i +: CODE_W] = key_codes[i];
      mid[CODE_W*i +: CODE_W] = key_codes[LETTERS_PER_WORD + i];
    end
    high = rand_word();
    high[KEY_HIGH_W-1:0] = {key_codes[25], key_codes[24]};
    len_word = rand_word();
    len_word[KEY_LEN_W-1:0] = len;
    program_key(low, mid, high, len_word);
  endtask

  task automatic random_keyword();
    for (int i = 0; i < ALPHABET_LETTERS; i++) begin
      if ($urandom_range(9) == 0) key_codes[i] = CODE_W'($urandom_range(31, ALPHABET_LETTERS));
      else key_codes[i] = CODE_W'($urandom_range(ALPHABET_LETTERS - 1));
    end
  endtask

  task automatic shuffled_alphabet();
    logic [CODE_W-1:0] swap;
    int j;
    for (int i = 0; i < ALPHABET_LETTERS; i++) key_codes[i] = CODE_W'(i);
    for (int i = ALPHABET_LETTERS - 1; i > 0; i--) begin
      j = $urandom_range(i);
      swap = key_codes[i];
      key_codes[i] = key_codes[j];
      key_codes[j] = swap;
    end
  endtask

  task automatic send_cipher(input logic [CHAR_W-1:0] c);
    if (!steady && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (!steady && $urandom_range(99) < 6);
    end
    in_valid <= 1'b1;
    in_cipher_char <= c;
    do @(posedge clk); while (!in_ready);
    tracker.note_cipher(c);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) tracker.check_plain(out_plain_char);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (hold_pending) begin
        hold_pending = 1'b0;
        stall_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 6);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset keyword: plain alphabet.
    foreach (PROBE_CHARS[i]) send_cipher(PROBE_CHARS[i]);
    drain_results();

    // A keyword with a repeated letter and a code above Z.
    random_keyword();
    key_codes[0] = 5'd10;
    key_codes[1] = 5'd4;
    key_codes[2] = 5'd24;
    key_codes[3] = 5'd22;
    key_codes[4] = 5'd14;
    key_codes[5] = 5'd17;
    key_codes[6] = 5'd3;
    key_codes[7] = 5'd4;
    key_codes[8] = 5'd27;
    key_codes[9] = 5'd25;
    load_keyword(5'd10);
    foreach (KEYED_PROBES[i]) send_cipher(KEYED_PROBES[i]);
    drain_results();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: program_key('1, '1, '1, '1);
        1: program_key('0, '0, '0, KEY_WORD_W'(ALPHABET_LETTERS));
        2: begin
          shuffled_alphabet();
          load_keyword(NUM_LETTERS);
          steady = 1'b1;
        end
        3: begin
          random_keyword();
          load_keyword(KEY_LEN_W'($urandom_range(31)));
          hold_pending = 1'b1;
        end
        4: begin
          write_reg(REG_KEY_LEN, rand_word());
          cfg_we <= 1'b0;
        end
        5: begin
          random_keyword();
          load_keyword('0);
        end
        6: begin
          write_reg(CFG_INDEX_W'($urandom_range(REG_KEY_HIGH)), rand_word());
          cfg_we <= 1'b0;
        end
        default: begin
          random_keyword();
          load_keyword(KEY_LEN_W'($urandom_range(31)));
        end
      endcase
      repeat (ITEMS_PER_PHASE) send_cipher(random_cipher());
      drain_results();
      steady = 1'b0;
    end

    repeat (60) @(posedge clk);
    if (tracker.faults == 0 && tracker.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
